// ===== rtl/core/sm83_alu_with_flags_unit_defines.svh =====
// Assertion macros for the SM83 ALU unit.
// Both expect clk and arst_n in scope at the point of use.
`ifndef SM83_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define SM83_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SM83ALU_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SM83ALU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sm83alu_pkg.sv =====
package sm83alu_pkg;

	typedef enum logic [5:0] {
		FN_ADD    = 6'd0,
		FN_ADC    = 6'd1,
		FN_SUB    = 6'd2,
		FN_SBC    = 6'd3,
		FN_AND    = 6'd4,
		FN_XOR    = 6'd5,
		FN_OR     = 6'd6,
		FN_CP     = 6'd7,
		FN_INC    = 6'd8,
		FN_DEC    = 6'd9,
		FN_RLCA   = 6'd10,
		FN_RRCA   = 6'd11,
		FN_RLA    = 6'd12,
		FN_RRA    = 6'd13,
		FN_DAA    = 6'd14,
		FN_CPL    = 6'd15,
		FN_SCF    = 6'd16,
		FN_CCF    = 6'd17,
		FN_RLC    = 6'd18,
		FN_RRC    = 6'd19,
		FN_RL     = 6'd20,
		FN_RR     = 6'd21,
		FN_SLA    = 6'd22,
		FN_SRA    = 6'd23,
		FN_SWAP   = 6'd24,
		FN_SRL    = 6'd25,
		FN_BIT    = 6'd26,
		FN_RES    = 6'd27,
		FN_SET    = 6'd28,
		FN_ADD16  = 6'd29,
		FN_ADDSP  = 6'd30,
		FN_INC16  = 6'd31,
		FN_DEC16  = 6'd32
	} func_t;

	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
	localparam logic [7:0] DAA_ADJ_HI   = 8'h60;

	typedef struct packed {
		logic [5:0]  func;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic        zero_in;
		logic        subtract_in;
		logic        half_carry_in;
		logic        carry_in;
	} in_word_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_result;
		logic        zero_out;
		logic        subtract_out;
		logic        half_carry_out;
		logic        carry_out;
	} out_word_t;

endpackage

// ===== rtl/core/sm83alu_if.sv =====
interface sm83alu_in_if ();
	import sm83alu_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sm83alu_out_if ();
	import sm83alu_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sm83alu_in_reg.sv =====
module sm83alu_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  sm83alu_pkg::in_word_t up_data,
	output logic                  valid_s1,
	input  logic                  dn_ready,
	output sm83alu_pkg::in_word_t data_s1
);
	import sm83alu_pkg::*;

	logic load;

	// Take a new word whenever the stage is empty or drains this cycle.
	assign up_ready = !valid_s1 || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= up_data;
		end
	end
endmodule

// ===== rtl/core/sm83alu_exec.sv =====
module sm83alu_exec (
	input  sm83alu_pkg::in_word_t  op,
	output sm83alu_pkg::out_word_t res
);
	import sm83alu_pkg::*;

	logic [7:0]  a;
	logic [7:0]  b;
	logic [15:0] wa;
	logic [15:0] wb;
	logic        cin;
	logic [8:0]  sum9;
	logic [4:0]  nib_sum;
	logic [8:0]  dif9;
	logic [4:0]  nib_dif;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [7:0]  daa_adj;
	logic [7:0]  daa_r;
	logic        daa_c;
	logic [7:0]  r8;
	logic        c8;
	logic [7:0]  bit_mask;

	assign a  = op.operand_a[7:0];
	assign b  = op.operand_b[7:0];
	assign wa = op.operand_a;
	assign wb = op.operand_b;

	// ADC and SBC fold in carry; the plain forms and CP use zero.
	assign cin = (func_t'(op.func) == FN_ADC || func_t'(op.func) == FN_SBC) ? op.carry_in : 1'b0;

	assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
	assign nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
	assign dif9    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
	assign nib_dif = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
	assign sum17   = {1'b0, wa} + {1'b0, wb};
	assign sum13   = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
	assign bit_mask = 8'd1 << op.bit_index;

	// DAA picks its adjustment from N, H, C and the original accumulator.
	always_comb begin
		daa_adj = 8'd0;
		daa_c   = op.carry_in;
		if (op.subtract_in) begin
			if (op.half_carry_in) daa_adj = daa_adj | DAA_ADJ_LO;
			if (op.carry_in) daa_adj = daa_adj | DAA_ADJ_HI;
			daa_r = a - daa_adj;
		end else begin
			if (op.half_carry_in || a[3:0] > DAA_LO_LIMIT) daa_adj = daa_adj | DAA_ADJ_LO;
			if (op.carry_in || a > DAA_HI_LIMIT) begin
				daa_adj = daa_adj | DAA_ADJ_HI;
				daa_c   = 1'b1;
			end
			daa_r = a + daa_adj;
		end
	end

	// CB shifts and rotates share the zero and carry rules.
	always_comb begin
		case (func_t'(op.func))
			FN_RLC:  begin r8 = {a[6:0], a[7]};          c8 = a[7]; end
			FN_RRC:  begin r8 = {a[0], a[7:1]};          c8 = a[0]; end
			FN_RL:   begin r8 = {a[6:0], op.carry_in};   c8 = a[7]; end
			FN_RR:   begin r8 = {op.carry_in, a[7:1]};   c8 = a[0]; end
			FN_SLA:  begin r8 = {a[6:0], 1'b0};          c8 = a[7]; end
			FN_SRA:  begin r8 = {a[7], a[7:1]};          c8 = a[0]; end
			FN_SRL:  begin r8 = {1'b0, a[7:1]};          c8 = a[0]; end
			default: begin r8 = {a[3:0], a[7:4]};        c8 = 1'b0; end
		endcase
	end

	always_comb begin
		res.result         = 16'd0;
		res.write_result   = 1'b1;
		res.zero_out       = op.zero_in;
		res.subtract_out   = op.subtract_in;
		res.half_carry_out = op.half_carry_in;
		res.carry_out      = op.carry_in;
		case (func_t'(op.func))
			FN_ADD, FN_ADC: begin
				res.result         = {8'd0, sum9[7:0]};
				res.zero_out       = (sum9[7:0] == 8'd0);
				res.subtract_out   = 1'b0;
				res.half_carry_out = nib_sum[4];
				res.carry_out      = sum9[8];
			end
			FN_SUB, FN_SBC, FN_CP: begin
				res.result         = {8'd0, dif9[7:0]};
				res.zero_out       = (dif9[7:0] == 8'd0);
				res.subtract_out   = 1'b1;
				res.half_carry_out = nib_dif[4];
				res.carry_out      = dif9[8];
				if (func_t'(op.func) == FN_CP) begin
					res.result       = 16'd0;
					res.write_result = 1'b0;
				end
			end
			FN_AND: begin
				res.result         = {8'd0, a & b};
				res.zero_out       = ((a & b) == 8'd0);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b1;
				res.carry_out      = 1'b0;
			end
			FN_XOR: begin
				res.result         = {8'd0, a ^ b};
				res.zero_out       = ((a ^ b) == 8'd0);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = 1'b0;
			end
			FN_OR: begin
				res.result         = {8'd0, a | b};
				res.zero_out       = ((a | b) == 8'd0);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = 1'b0;
			end
			FN_INC: begin
				res.result         = {8'd0, a + 8'd1};
				res.zero_out       = (a == 8'hFF);
				res.subtract_out   = 1'b0;
				res.half_carry_out = (a[3:0] == 4'hF);
			end
			FN_DEC: begin
				res.result         = {8'd0, a - 8'd1};
				res.zero_out       = (a == 8'd1);
				res.subtract_out   = 1'b1;
				res.half_carry_out = (a[3:0] == 4'h0);
			end
			FN_RLCA, FN_RLA: begin
				res.result         = {8'd0, a[6:0],
					(func_t'(op.func) == FN_RLCA) ? a[7] : op.carry_in};
				res.zero_out       = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = a[7];
			end
			FN_RRCA, FN_RRA: begin
				res.result         = {8'd0,
					(func_t'(op.func) == FN_RRCA) ? a[0] : op.carry_in, a[7:1]};
				res.zero_out       = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = a[0];
			end
			FN_DAA: begin
				res.result         = {8'd0, daa_r};
				res.zero_out       = (daa_r == 8'd0);
				res.half_carry_out = 1'b0;
				res.carry_out      = daa_c;
			end
			FN_CPL: begin
				res.result         = {8'd0, ~a};
				res.subtract_out   = 1'b1;
				res.half_carry_out = 1'b1;
			end
			FN_SCF: begin
				res.write_result   = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = 1'b1;
			end
			FN_CCF: begin
				res.write_result   = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = !op.carry_in;
			end
			FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP, FN_SRL: begin
				res.result         = {8'd0, r8};
				res.zero_out       = (r8 == 8'd0);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = c8;
			end
			FN_BIT: begin
				res.write_result   = 1'b0;
				res.zero_out       = !a[op.bit_index];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b1;
			end
			FN_RES: begin
				res.result = {8'd0, a & ~bit_mask};
			end
			FN_SET: begin
				res.result = {8'd0, a | bit_mask};
			end
			FN_ADD16: begin
				res.result         = sum17[15:0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = sum13[12];
				res.carry_out      = sum17[16];
			end
			FN_ADDSP: begin
				// H and C come from the unsigned low-byte add; the offset is signed.
				res.result         = wa + {{8{b[7]}}, b};
				res.zero_out       = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = nib_sum[4];
				res.carry_out      = sum9[8];
			end
			FN_INC16: begin
				res.result = wa + 16'd1;
			end
			FN_DEC16: begin
				res.result = wa - 16'd1;
			end
			default: begin
				res.write_result = 1'b0;
			end
		endcase
	end
endmodule

// ===== rtl/core/sm83alu_out_reg.sv =====
module sm83alu_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  sm83alu_pkg::out_word_t up_data,
	output logic                   valid_s2,
	input  logic                   dn_ready,
	output sm83alu_pkg::out_word_t data_s2
);
	import sm83alu_pkg::*;

	logic load;

	// Hold the result while the sink stalls; refill as it drains.
	assign up_ready = !valid_s2 || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= up_data;
		end
	end
endmodule

// ===== rtl/core/sm83_alu_with_flags_unit.sv =====
// Channel   Modport  Word        Notes
// alu_in    sink     in_word_t   operation, operands, bit index, flags in
// alu_out   source   out_word_t  result, write enable, flags out
//
// A word passes from input accept to result valid through one input register
// and one result register, with the ALU logic between them.
// Throughput is one word per clock while alu_out is ready.
// arst_n clears both valid bits; payload registers are not reset.
// A stall on alu_out backs up through the result and input registers, so
// alu_in stays ready until both hold a word.
module sm83_alu_with_flags_unit (
	input  logic               clk,
	input  logic               arst_n,
	sm83alu_in_if.sink         alu_in,
	sm83alu_out_if.source      alu_out
);
	import sm83alu_pkg::*;
	`include "sm83_alu_with_flags_unit_defines.svh"

	logic      valid_s1;
	logic      ready_s2;
	in_word_t  data_s1;
	out_word_t exec_res;
	out_word_t data_s2;
	logic      valid_s2;

	sm83alu_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (alu_in.valid),
		.up_ready (alu_in.ready),
		.up_data  (alu_in.data),
		.valid_s1 (valid_s1),
		.dn_ready (ready_s2),
		.data_s1  (data_s1)
	);

	sm83alu_exec u_exec (
		.op  (data_s1),
		.res (exec_res)
	);

	sm83alu_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s2),
		.up_data  (exec_res),
		.valid_s2 (valid_s2),
		.dn_ready (alu_out.ready),
		.data_s2  (data_s2)
	);

	assign alu_out.valid = valid_s2;
	assign alu_out.data  = data_s2;

	`SM83ALU_ASSERT(a_stall_only_full, alu_in.valid && !alu_in.ready,
		valid_s1 && valid_s2, "input stalled with a pipeline slot free")
	`SM83ALU_ASSERT_NEXT(a_accept_fills_s1, alu_in.valid && alu_in.ready,
		valid_s1, "accepted word lost in input stage")
	`SM83ALU_ASSERT_NEXT(a_s1_to_s2, valid_s1 && ready_s2,
		valid_s2 && data_s2 == $past(exec_res), "result not captured from input stage")
	`SM83ALU_ASSERT_NEXT(a_drain_empties, alu_out.valid && alu_out.ready && !valid_s1,
		!alu_out.valid, "result repeated after drain")
endmodule
